@@ sv/hsl2rgb_pkg.sv @@
`default_nettype none

package hsl2rgb_pkg;

	localparam int FRAC_BITS_DEF = 24;

	// channel select for the per-channel ramp unit
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	// piece of the hue ramp that an offset falls in
	localparam logic [1:0] RG_RISE = 2'd0;
	localparam logic [1:0] RG_TOP  = 2'd1;
	localparam logic [1:0] RG_FALL = 2'd2;
	localparam logic [1:0] RG_BASE = 2'd3;

endpackage

`default_nettype wire

@@ sv/hsl2rgb_chan.sv @@
`default_nettype none

module hsl2rgb_chan #(
	parameter int         FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF,
	parameter logic [1:0] CHANNEL   = hsl2rgb_pkg::CH_GREEN
) (
	input  wire logic                 clk,
	input  wire logic [5:1]           en,
	input  wire logic [FRAC_BITS:0]   h_w,
	input  wire logic [FRAC_BITS:0]   diff_s3,
	input  wire logic [FRAC_BITS:0]   p_s4,
	input  wire logic [FRAC_BITS:0]   q_s4,
	input  wire logic [FRAC_BITS:0]   l_s4,
	input  wire logic                 szero_s4,
	output logic      [7:0]           byte_s5
);
	import hsl2rgb_pkg::*;

	localparam int W  = FRAC_BITS + 1;
	localparam int TW = FRAC_BITS + 3;
	localparam longint unsigned ONE_L = 64'd1 << FRAC_BITS;
	localparam logic [W-1:0] SIXTH      = W'(ONE_L / 6);
	localparam logic [W-1:0] HALF       = W'(ONE_L / 2);
	localparam logic [W-1:0] TWO_THIRDS = W'((2 * ONE_L) / 3);
	localparam logic signed [TW-1:0] ONE_S   = TW'(ONE_L);
	localparam logic signed [TW-1:0] THIRD_S = TW'(ONE_L / 3);

	logic signed [TW-1:0] t_ofs;
	logic signed [TW-1:0] t_wrap;
	logic [W-1:0]         t_s1;

	logic [W-1:0]         span;
	logic [W+2:0]         six_span;
	logic [1:0]           region;
	logic [W-1:0]         factor;
	logic [1:0]           region_s2;
	logic [W-1:0]         factor_s2;
	logic [1:0]           region_s3;
	logic [W-1:0]         factor_s3;

	logic [2*W-1:0]       prod;
	logic [1:0]           region_s4;
	logic [W-1:0]         m_s4;

	logic [W:0]           v;
	logic [W+8:0]         scaled;
	logic [9:0]           x;

	// stage 1: offset hue and wrap into [0, 1]
	always_comb begin
		case (CHANNEL)
			CH_RED:   t_ofs = signed'(TW'(h_w)) + THIRD_S;
			CH_BLUE:  t_ofs = signed'(TW'(h_w)) - THIRD_S;
			default:  t_ofs = signed'(TW'(h_w));
		endcase
		t_wrap = t_ofs;
		if (t_wrap < 0) begin
			t_wrap = t_wrap + ONE_S;
		end else if (t_wrap > ONE_S) begin
			t_wrap = t_wrap - ONE_S;
		end
	end

	// stage 2: ramp piece and slope factor
	always_comb begin
		if (t_s1 < SIXTH) begin
			region = RG_RISE;
			span   = t_s1;
		end else if (t_s1 < HALF) begin
			region = RG_TOP;
			span   = '0;
		end else if (t_s1 < TWO_THIRDS) begin
			region = RG_FALL;
			span   = TWO_THIRDS - t_s1;
		end else begin
			region = RG_BASE;
			span   = '0;
		end
		six_span = ((W+3)'(span) << 2) + ((W+3)'(span) << 1);
		factor   = W'(six_span);
	end

	assign prod = (2*W)'(diff_s3) * (2*W)'(factor_s3);

	// stage 5: pick value, scale by 255 with rounding, clamp
	always_comb begin
		if (szero_s4) begin
			v = (W+1)'(l_s4);
		end else begin
			case (region_s4)
				RG_RISE, RG_FALL: v = (W+1)'(p_s4) + (W+1)'(m_s4);
				RG_TOP:           v = (W+1)'(q_s4);
				default:          v = (W+1)'(p_s4);
			endcase
		end
		scaled = ((W+9)'(v) << 8) - (W+9)'(v) + (W+9)'(HALF);
		x      = 10'(scaled >> FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			t_s1 <= W'(t_wrap);
		end
		if (en[2]) begin
			region_s2 <= region;
			factor_s2 <= factor;
		end
		if (en[3]) begin
			region_s3 <= region_s2;
			factor_s3 <= factor_s2;
		end
		if (en[4]) begin
			region_s4 <= region_s3;
			m_s4      <= W'(prod >> FRAC_BITS);
		end
		if (en[5]) begin
			byte_s5 <= (x > 10'd255) ? 8'd255 : x[7:0];
		end
	end

endmodule

`default_nettype wire

@@ sv/hsl_to_rgb565_converter.sv @@
`default_nettype none

// HSL to RGB565 converter. Hue, saturation and luminance are unsigned Q1.15
// (32768 = 1.0, larger values saturate to 1.0); the result is a packed RGB565
// word, red in bits 15..11, green 10..5, blue 4..0. Arithmetic is fixed point
// with FRAC_BITS fractional bits and truncated products. The datapath is a
// five-stage pipeline: one transaction is accepted per clock while hsl_ready
// is high; its result moves through stage registers 1 to 5 and is presented
// from stage 5 until rgb_ready takes it. A full stage holds while its
// successor is full and stalled, so bubbles are squeezed out and hsl_ready
// only drops when all five stages are occupied.
module hsl_to_rgb565_converter #(
	parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        hsl_valid,
	output logic             hsl_ready,
	input  wire logic [15:0] hue,
	input  wire logic [15:0] saturation,
	input  wire logic [15:0] luminance,
	output logic             rgb_valid,
	input  wire logic        rgb_ready,
	output logic      [15:0] rgb565
);
	import hsl2rgb_pkg::*;

	localparam int W = FRAC_BITS + 1;
	localparam longint unsigned ONE_L = 64'd1 << FRAC_BITS;
	localparam logic [W-1:0] HALF = W'(ONE_L / 2);
	localparam logic [15:0]  IN_MAX = 16'd32768;

	logic [5:1]     v_q;
	logic [6:1]     en;

	logic [W-1:0]   h_w, s_w, l_w;
	logic [2*W-1:0] ls_prod;

	logic [W-1:0]   l_s1, s_s1, ls_s1;
	logic           szero_s1;

	logic [W:0]     q_sum;
	logic [W-1:0]   q_s2, l_s2;
	logic           szero_s2;

	logic [W:0]     l2, q_ext, q2;
	logic [W-1:0]   p_nxt, diff_nxt;
	logic [W-1:0]   p_s3, q_s3, l_s3, diff_s3;
	logic           szero_s3;

	logic [W-1:0]   p_s4, q_s4, l_s4;
	logic           szero_s4;

	logic [7:0]     r_s5, g_s5, b_s5;

	// stage enables: a stage moves when empty or when its successor moves
	always_comb begin
		en[6] = rgb_ready;
		for (int k = 5; k >= 1; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	assign hsl_ready = en[1];
	assign rgb_valid = v_q[5];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) begin
				v_q[1] <= hsl_valid;
			end
			for (int k = 2; k <= 5; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	// widen Q1.15 to the internal format, saturating at 1.0
	assign h_w = W'((hue        > IN_MAX) ? IN_MAX : hue)        << (FRAC_BITS - 15);
	assign s_w = W'((saturation > IN_MAX) ? IN_MAX : saturation) << (FRAC_BITS - 15);
	assign l_w = W'((luminance  > IN_MAX) ? IN_MAX : luminance)  << (FRAC_BITS - 15);

	assign ls_prod = (2*W)'(l_w) * (2*W)'(s_w);

	always_comb begin
		if (l_s1 < HALF) begin
			q_sum = (W+1)'(l_s1) + (W+1)'(ls_s1);
		end else begin
			q_sum = (W+1)'(l_s1) + (W+1)'(s_s1) - (W+1)'(ls_s1);
		end
	end

	// p = 2l - q floored at zero; q - p computed alongside
	always_comb begin
		l2    = (W+1)'(l_s2) << 1;
		q_ext = (W+1)'(q_s2);
		q2    = q_ext << 1;
		p_nxt = (l2 > q_ext) ? W'(l2 - q_ext) : '0;
		if (l2 <= q_ext) begin
			diff_nxt = q_s2;
		end else if (q2 > l2) begin
			diff_nxt = W'(q2 - l2);
		end else begin
			diff_nxt = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			l_s1     <= l_w;
			s_s1     <= s_w;
			ls_s1    <= W'(ls_prod >> FRAC_BITS);
			szero_s1 <= (s_w == '0);
		end
		if (en[2]) begin
			q_s2     <= W'(q_sum);
			l_s2     <= l_s1;
			szero_s2 <= szero_s1;
		end
		if (en[3]) begin
			p_s3     <= p_nxt;
			q_s3     <= q_s2;
			l_s3     <= l_s2;
			diff_s3  <= diff_nxt;
			szero_s3 <= szero_s2;
		end
		if (en[4]) begin
			p_s4     <= p_s3;
			q_s4     <= q_s3;
			l_s4     <= l_s3;
			szero_s4 <= szero_s3;
		end
	end

	hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS), .CHANNEL(CH_RED)) u_red (
		.clk      (clk),
		.en       (en[5:1]),
		.h_w      (h_w),
		.diff_s3  (diff_s3),
		.p_s4     (p_s4),
		.q_s4     (q_s4),
		.l_s4     (l_s4),
		.szero_s4 (szero_s4),
		.byte_s5  (r_s5)
	);

	hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS), .CHANNEL(CH_GREEN)) u_green (
		.clk      (clk),
		.en       (en[5:1]),
		.h_w      (h_w),
		.diff_s3  (diff_s3),
		.p_s4     (p_s4),
		.q_s4     (q_s4),
		.l_s4     (l_s4),
		.szero_s4 (szero_s4),
		.byte_s5  (g_s5)
	);

	hsl2rgb_chan #(.FRAC_BITS(FRAC_BITS), .CHANNEL(CH_BLUE)) u_blue (
		.clk      (clk),
		.en       (en[5:1]),
		.h_w      (h_w),
		.diff_s3  (diff_s3),
		.p_s4     (p_s4),
		.q_s4     (q_s4),
		.l_s4     (l_s4),
		.szero_s4 (szero_s4),
		.byte_s5  (b_s5)
	);

	assign rgb565 = {r_s5[7:3], g_s5[7:2], b_s5[7:3]};

endmodule

`default_nettype wire
